### hw/rtl/mgds_pkg.sv
// Shared types and constants for the masked gamma 2x2 downsampler.
`default_nettype none
package mgds_pkg;
    localparam logic       CMD_PIXEL  = 1'b0;
    localparam logic       CMD_TABLE  = 1'b1;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CHAN   = 2'd1;
    localparam logic [1:0] REG_NODATA = 2'd2;
    localparam logic [7:0] VALID_LEVEL = 8'd127;
    localparam logic [7:0] FULL_MASK   = 8'd255;
    localparam logic [9:0] TABLE_TOP   = 10'd1020;
    localparam logic [12:0] RECIP3     = 13'd2731;

    typedef struct packed {
        logic [3:0][8:0] sum;
        logic [1:0]      cnt;
    } partial_t;

    typedef struct packed {
        logic       accept;
        logic       load;
        logic       gread;
        logic       gcap;
        logic       emit;
        logic [1:0] ch_idx;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_load;
        logic avg;
        logic last_ch;
        logic out_free;
    } dp_stat_t;
endpackage
`default_nettype wire

### hw/rtl/masked_gamma_downsample_2x2.sv
// Masked 2x2 box downsampler with gamma lookup: top level.
// Input channel (in_valid/in_stall) carries pixel requests in raster order,
// 2*out_width per input row, and gamma table write requests (cmd = 1).
// Output channel (out_valid/out_stall) carries one downsampled pixel per
// completed 2x2 quad, on the odd-column request of each odd input row.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle; the
// user must keep to this, as the block itself does not enforce it.
// A table write or a request that yields no pixel does not stall the input.
// A quad-completing request first reads the line store; on the background
// path it then emits, and when averaged each channel first needs one pass
// through the single-port gamma table (address, then registered read data).
// The output register lets a new request be taken while a pixel waits;
// a request that must emit holds in its last state until the output frees.
// Reset clears the row/column position, the pair sums and the output valid
// flag; configuration returns to width 256, 3 channels, nodata 0.
// The line store and gamma table are not cleared; load the table first.
`default_nettype none
module masked_gamma_downsample_2x2
    import mgds_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 4096,
    parameter int MAX_CHANNELS  = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] pixel_samples,
    input  wire logic [7:0]  pixel_mask,
    input  wire logic [31:0] bg_samples,
    input  wire logic [7:0]  bg_mask,
    input  wire logic [9:0]  table_index,
    input  wire logic [7:0]  table_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_samples,
    output logic [7:0]       out_mask,
    output logic             out_row_end
);
    ctl_cmd_t ctl;
    dp_stat_t stat;

    mgds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (ctl)
    );

    mgds_datapath #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_CHANNELS  (MAX_CHANNELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .pixel_samples (pixel_samples),
        .pixel_mask    (pixel_mask),
        .bg_samples    (bg_samples),
        .bg_mask       (bg_mask),
        .table_index   (table_index),
        .table_value   (table_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_samples   (out_samples),
        .out_mask      (out_mask),
        .out_row_end   (out_row_end),
        .ctl           (ctl),
        .stat          (stat)
    );
endmodule
`default_nettype wire

### hw/rtl/mgds_ctrl.sv
// Sequencing controller for the masked gamma 2x2 downsampler.
`default_nettype none
module mgds_ctrl
    import mgds_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  dp_stat_t      stat,
    output ctl_cmd_t      cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_GREAD = 3'd2;
    localparam logic [2:0] S_GCAP  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] ch_reg, ch_next;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.ch_idx = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && stat.need_load)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                ch_next    = 2'd0;
                state_next = stat.avg ? S_GREAD : S_EMIT;
            end
            S_GREAD:
            begin
                cmd.gread  = 1'b1;
                state_next = S_GCAP;
            end
            S_GCAP:
            begin
                cmd.gcap = 1'b1;
                if (stat.last_ch)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_GREAD;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mgds_datapath.sv
// Datapath: config, pair sums, line store, gamma table and output register.
`default_nettype none
module mgds_datapath
    import mgds_pkg::*;
#(
    parameter int MAX_OUT_WIDTH = 4096,
    parameter int MAX_CHANNELS  = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        cmd,
    input  wire logic [31:0] pixel_samples,
    input  wire logic [7:0]  pixel_mask,
    input  wire logic [31:0] bg_samples,
    input  wire logic [7:0]  bg_mask,
    input  wire logic [9:0]  table_index,
    input  wire logic [7:0]  table_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_samples,
    output logic [7:0]       out_mask,
    output logic             out_row_end,
    input  ctl_cmd_t         ctl,
    output dp_stat_t         stat
);
    localparam int IDX_W = $clog2(MAX_OUT_WIDTH);
    localparam int COL_W = IDX_W + 1;
    localparam int EXT_W = IDX_W + 2;

    logic [12:0] width_reg;
    logic [2:0]  chan_reg;
    logic [31:0] nodata_reg;
    logic [COL_W-1:0] col_reg;
    logic        row_reg;
    partial_t    pair_reg;

    partial_t    line_mem [MAX_OUT_WIDTH];
    partial_t    ls_rd_reg;
    logic [7:0]  gamma_mem [1024];
    logic [7:0]  gam_rd_reg;

    partial_t    p_reg;
    logic [31:0] bg_reg;
    logic [7:0]  bgm_reg;
    logic        last_reg;
    logic [3:0][9:0] tot_reg;
    logic [2:0]  tcnt_reg;
    logic [31:0] res_reg;
    logic [7:0]  rmask_reg;
    logic        out_valid_reg;
    logic [31:0] out_samples_reg;
    logic [7:0]  out_mask_reg;
    logic        out_row_end_reg;

    logic [31:0]      w_full;
    logic [IDX_W:0]   w_eff;
    logic [2:0]       ch_eff;
    logic [EXT_W-1:0] w2, col_ext, col1;
    logic             wrap0, wrap1, row0, pv;
    logic [COL_W-1:0] col0, col_next;
    logic [IDX_W-1:0] idx;
    partial_t         pix, p_new;
    logic             pix_item, last0;
    logic [3:0][9:0]  tot_new;
    logic [2:0]       tcnt_new;
    logic [31:0]      bg_src, bg_res;
    logic [11:0]      xs;
    logic [24:0]      prod;
    logic [11:0]      q;
    logic [9:0]       ix;

    always_comb
    begin
        w_full = {19'd0, width_reg};
        if (w_full == 32'd0)
        begin
            w_full = 32'd1;
        end
        if (w_full > 32'(MAX_OUT_WIDTH))
        begin
            w_full = 32'(MAX_OUT_WIDTH);
        end
        w_eff  = w_full[IDX_W:0];
        ch_eff = (chan_reg == 3'd0) ? 3'd1 : chan_reg;
        if (32'(ch_eff) > 32'(MAX_CHANNELS))
        begin
            ch_eff = 3'(MAX_CHANNELS);
        end
    end

    always_comb
    begin
        w2       = {w_eff, 1'b0};
        col_ext  = {1'b0, col_reg};
        wrap0    = (col_ext >= w2);
        col0     = wrap0 ? '0 : col_reg;
        row0     = row_reg ^ wrap0;
        col1     = {1'b0, col0} + EXT_W'(1);
        wrap1    = (col1 >= w2);
        col_next = wrap1 ? '0 : col1[COL_W-1:0];
        idx      = col0[IDX_W:1];
        last0    = ({1'b0, col0[IDX_W:1]} == (w_eff - (IDX_W+1)'(1)));
        pv       = (pixel_mask >= VALID_LEVEL);
        pix_item = (cmd == CMD_PIXEL);
        for (int c = 0; c < 4; c++)
        begin
            pix.sum[c] = (pv && (c < 32'(ch_eff))) ? {1'b0, pixel_samples[c*8 +: 8]} : 9'd0;
            p_new.sum[c] = col0[0] ? (pair_reg.sum[c] + pix.sum[c]) : pix.sum[c];
        end
        pix.cnt   = {1'b0, pv};
        p_new.cnt = col0[0] ? (pair_reg.cnt + pix.cnt) : pix.cnt;
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            tot_new[c] = {1'b0, ls_rd_reg.sum[c]} + {1'b0, p_reg.sum[c]};
        end
        tcnt_new = {1'b0, ls_rd_reg.cnt} + {1'b0, p_reg.cnt};
        bg_src   = (bgm_reg < VALID_LEVEL) ? nodata_reg : bg_reg;
        for (int c = 0; c < 4; c++)
        begin
            bg_res[c*8 +: 8] = (c < 32'(ch_eff)) ? bg_src[c*8 +: 8] : 8'd0;
        end
        xs   = {tot_reg[ctl.ch_idx], 2'b00};
        prod = {13'd0, xs} * {12'd0, RECIP3};
        case (tcnt_reg)
            3'd2:    q = {1'b0, xs[11:1]};
            3'd3:    q = prod[24:13];
            default: q = {2'b00, xs[11:2]};
        endcase
        ix = (q > {2'b00, TABLE_TOP}) ? TABLE_TOP : q[9:0];
    end

    assign stat.need_load = pix_item && col0[0] && row0;
    assign stat.avg       = (tcnt_new >= 3'd2);
    assign stat.last_ch   = ({1'b0, ctl.ch_idx} == (ch_eff - 3'd1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (ctl.accept && pix_item && col0[0] && !row0)
        begin
            line_mem[idx] <= p_new;
        end
        if (ctl.accept && stat.need_load)
        begin
            ls_rd_reg <= line_mem[idx];
        end
        if (ctl.accept && !pix_item)
        begin
            gamma_mem[table_index] <= table_value;
        end
        if (ctl.gread)
        begin
            gam_rd_reg <= gamma_mem[ix];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            p_reg    <= p_new;
            bg_reg   <= bg_samples;
            bgm_reg  <= bg_mask;
            last_reg <= last0;
        end
        if (ctl.load)
        begin
            tot_reg   <= tot_new;
            tcnt_reg  <= tcnt_new;
            res_reg   <= stat.avg ? 32'd0 : bg_res;
            rmask_reg <= stat.avg ? FULL_MASK : bgm_reg;
        end
        if (ctl.gcap)
        begin
            res_reg[ctl.ch_idx*8 +: 8] <= gam_rd_reg;
        end
        if (ctl.emit)
        begin
            out_samples_reg <= res_reg;
            out_mask_reg    <= rmask_reg;
            out_row_end_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 13'd256;
            chan_reg      <= 3'd3;
            nodata_reg    <= 32'd0;
            col_reg       <= '0;
            row_reg       <= 1'b0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_wdata[12:0];
                    REG_CHAN:   chan_reg   <= cfg_wdata[2:0];
                    REG_NODATA: nodata_reg <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (ctl.accept && pix_item)
            begin
                col_reg  <= col_next;
                row_reg  <= row0 ^ wrap1;
                pair_reg <= p_new;
            end
            if (ctl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_samples = out_samples_reg;
    assign out_mask    = out_mask_reg;
    assign out_row_end = out_row_end_reg;
endmodule
`default_nettype wire

### verif/masked_gamma_downsample_2x2_tb.sv
// Testbench for the masked gamma 2x2 downsampler: directed table plus randomized checks.
`timescale 1ns / 100ps
`default_nettype none
module masked_gamma_downsample_2x2_tb;
    import mgds_pkg::*;

    typedef struct {
        logic [31:0] samples;
        logic [7:0]  mask;
        logic        row_end;
    } pixel_out_t;

    typedef struct {
        logic        op;
        logic [31:0] px;
        logic [7:0]  pm;
        logic [31:0] bg;
        logic [7:0]  bm;
        logic [9:0]  ti;
        logic [7:0]  tv;
        logic        has;
        logic [31:0] es;
        logic [7:0]  em;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        cmd;
    logic [31:0] pixel_samples;
    logic [7:0]  pixel_mask;
    logic [31:0] bg_samples;
    logic [7:0]  bg_mask;
    logic [9:0]  table_index;
    logic [7:0]  table_value;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_samples;
    logic [7:0]  out_mask;
    logic        out_row_end;

    masked_gamma_downsample_2x2 uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .pixel_samples(pixel_samples), .pixel_mask(pixel_mask),
        .bg_samples(bg_samples), .bg_mask(bg_mask),
        .table_index(table_index), .table_value(table_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_samples(out_samples), .out_mask(out_mask), .out_row_end(out_row_end)
    );

    // predictor state
    logic [12:0] width_reg;
    logic [2:0]  chan_reg;
    logic [31:0] nodata_reg;
    int          col_pos;
    bit          row_odd;
    int          pair_sum [4];
    int          pair_cnt;
    int          line_sum [4096][4];
    int          line_cnt [4096];
    logic [7:0]  gamma [1024];

    pixel_out_t pixel_due [$];
    int  errors;
    int  idle_cycles;
    bit  hold_req;
    int  burst_left;
    bit  no_gaps;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        if (width_reg > 4096) return 4096;
        return width_reg;
    endfunction

    function automatic int eff_chan();
        if (chan_reg == 0) return 1;
        if (chan_reg > 4) return 4;
        return chan_reg;
    endfunction

    // returns 1 when the request completes a quad
    function automatic bit downsample_step(input logic [31:0] px, input logic [7:0] pm,
                                           input logic [31:0] bg, input logic [7:0] bm,
                                           output pixel_out_t res);
        int w;
        int ch;
        int idx;
        int psum [4];
        int pcnt;
        int tcnt;
        int ix;
        bit produced;
        w = eff_width();
        ch = eff_chan();
        produced = 0;
        res.samples = 0;
        res.mask = 0;
        res.row_end = 0;
        if (col_pos >= 2 * w)
        begin
            col_pos = 0;
            row_odd = !row_odd;
        end
        if (col_pos % 2 == 0)
        begin
            pair_cnt = 0;
            for (int c = 0; c < 4; c++) pair_sum[c] = 0;
            if (pm >= VALID_LEVEL)
            begin
                pair_cnt = 1;
                for (int c = 0; c < ch; c++) pair_sum[c] = px[8*c +: 8];
            end
        end
        else
        begin
            idx = (col_pos >> 1) & 4095;
            pcnt = pair_cnt;
            for (int c = 0; c < 4; c++) psum[c] = pair_sum[c];
            if (pm >= VALID_LEVEL)
            begin
                pcnt++;
                for (int c = 0; c < ch; c++) psum[c] += px[8*c +: 8];
            end
            if (!row_odd)
            begin
                line_cnt[idx] = pcnt;
                for (int c = 0; c < 4; c++) line_sum[idx][c] = psum[c];
            end
            else
            begin
                tcnt = line_cnt[idx] + pcnt;
                if (tcnt >= 2)
                begin
                    for (int c = 0; c < ch; c++)
                    begin
                        ix = ((line_sum[idx][c] + psum[c]) * 4) / tcnt;
                        if (ix > TABLE_TOP) ix = TABLE_TOP;
                        res.samples[8*c +: 8] = gamma[ix];
                    end
                    res.mask = FULL_MASK;
                end
                else
                begin
                    for (int c = 0; c < ch; c++)
                        res.samples[8*c +: 8] = (bm < VALID_LEVEL) ? nodata_reg[8*c +: 8]
                                                                 : bg[8*c +: 8];
                    res.mask = bm;
                end
                res.row_end = ((col_pos >> 1) == w - 1);
                produced = 1;
            end
        end
        col_pos++;
        if (col_pos >= 2 * w)
        begin
            col_pos = 0;
            row_odd = !row_odd;
        end
        return produced;
    endfunction

    // called at a falling edge; returns at a falling edge with the request taken
    task automatic send_req(input logic op, input logic [31:0] px, input logic [7:0] pm,
                            input logic [31:0] bg, input logic [7:0] bm,
                            input logic [9:0] ti, input logic [7:0] tv,
                            input bit has, input logic [31:0] es, input logic [7:0] em);
        pixel_out_t res;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= op;
        pixel_samples <= px;
        pixel_mask <= pm;
        bg_samples <= bg;
        bg_mask <= bm;
        table_index <= ti;
        table_value <= tv;
        do @(posedge clk); while (in_stall);
        if (op == CMD_TABLE)
            gamma[ti] = tv;
        else if (downsample_step(px, pm, bg, bm, res))
        begin
            if (has)
            begin
                res.samples = es;
                res.mask = em;
                res.row_end = 1'b1;
            end
            pixel_due.push_back(res);
        end
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd126;
            2: return 8'd127;
            3: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // keep samples below 64 so every lookup lands in the loaded part of the table
    task automatic send_pixel();
        send_req(CMD_PIXEL, $urandom & 32'h3F3F3F3F, pick_mask(), $urandom, pick_mask(),
                 10'($urandom), 8'($urandom), 0, 0, 0);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req(CMD_TABLE, $urandom, 8'($urandom), $urandom, 8'($urandom),
                         10'($urandom_range(0, 1023)), 8'($urandom), 0, 0, 0);
            else
                send_pixel();
        end
    endtask

    task automatic finish_pair();
        while (col_pos != 0 || row_odd)
        begin
            if (col_pos >= 2 * eff_width())
            begin
                if (row_odd) break;
            end
            send_pixel();
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pixel_due.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH: width_reg = val[12:0];
            REG_CHAN:  chan_reg = val[2:0];
            default:   nodata_reg = val;
        endcase
    endtask

    task automatic set_phase(input logic [31:0] w, input logic [31:0] ch,
                             input logic [31:0] nd);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_CHAN, ch);
        write_reg(REG_NODATA, nd);
    endtask

    dir_row_t steps [22] = '{
        '{CMD_TABLE, 0, 0, 0, 0, 10'd1023, 8'h5A, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'hFF, 32'h0, 8'h00, 0, 0, 1, 32'hFFFFFFFF, 8'hFF},
        '{CMD_PIXEL, 32'h11223344, 8'h00, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'h55667788, 8'h00, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'h99AABBCC, 8'h00, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hDDEEFF00, 8'h00, 32'hFFFFFFFF, 8'h00, 0, 0, 1, 32'hA5C31E77, 8'h00},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd126, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd126, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd126, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd126, 32'h12345678, 8'd127, 0, 0, 1, 32'h12345678, 8'd127},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd127, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_TABLE, 0, 0, 0, 0, 10'd1021, 8'hC3, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'hFFFFFFFF, 8'd0, 32'h00000000, 8'hFF, 0, 0, 1, 32'h0, 8'hFF},
        '{CMD_PIXEL, 32'h00000000, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'h00000000, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'h00000000, 8'hFF, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_PIXEL, 32'h00000000, 8'hFF, 32'hFFFFFFFF, 8'hFF, 0, 0, 1, 32'h0, 8'hFF}
    };

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = CMD_PIXEL;
        pixel_samples = '0;
        pixel_mask = '0;
        bg_samples = '0;
        bg_mask = '0;
        table_index = '0;
        table_value = '0;
        errors = 0;
        hold_req = 0;
        burst_left = 0;
        no_gaps = 0;
        width_reg = 13'd256;
        chan_reg = 3'd3;
        nodata_reg = '0;
        col_pos = 0;
        row_odd = 0;
        pair_cnt = 0;
        for (int c = 0; c < 4; c++) pair_sum[c] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // load an averaging curve: entry i holds i/4, plus the top entry
        for (int i = 0; i < 256; i++)
            send_req(CMD_TABLE, 0, 0, 0, 0, 10'(i), 8'(i >> 2), 0, 0, 0);
        send_req(CMD_TABLE, 0, 0, 0, 0, TABLE_TOP, 8'hFF, 0, 0, 0);
        set_phase(1, 4, 32'hA5C31E77);
        foreach (steps[i])
            send_req(steps[i].op, steps[i].px, steps[i].pm, steps[i].bg, steps[i].bm,
                     steps[i].ti, steps[i].tv, steps[i].has, steps[i].es, steps[i].em);

        hold_req = 1;
        set_phase(0, 1, $urandom);
        send_random(30);
        finish_pair();
        set_phase(3, 2, 32'hFFFFFFFF);
        no_gaps = 1;
        send_random(40);
        finish_pair();
        no_gaps = 0;
        set_phase(7, 0, $urandom);
        send_random(50);
        finish_pair();
        set_phase(5, 7, $urandom);
        send_random(40);
        finish_pair();
        set_phase(2, 3, 0);
        send_random(40);
        finish_pair();

        // shrink the row mid-way through an even row
        set_phase(4, 4, $urandom);
        repeat (6) send_pixel();
        drain();
        write_reg(REG_WIDTH, 2);
        send_random(20);
        finish_pair();

        set_phase(13'h1FFF, 4, $urandom);
        send_random(30);
        drain();
        write_reg(REG_WIDTH, 3);
        send_random(10);
        finish_pair();
        set_phase(6, 3, $urandom);
        send_random(40);
        finish_pair();

        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int mode;
        out_stall = 1'b0;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (200) @(negedge clk);
                hold_req = 0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pixel_due.size() == 0)
            begin
                $display("%0t: unexpected pixel %h mask %h row_end %b", $time,
                         out_samples, out_mask, out_row_end);
                errors++;
            end
            else
            begin
                want = pixel_due.pop_front();
                if (out_samples !== want.samples)
                begin
                    $display("%0t: samples expected %h actual %h", $time,
                             want.samples, out_samples);
                    errors++;
                end
                if (out_mask !== want.mask)
                begin
                    $display("%0t: mask expected %h actual %h", $time, want.mask, out_mask);
                    errors++;
                end
                if (out_row_end !== want.row_end)
                begin
                    $display("%0t: row_end expected %b actual %b", $time,
                             want.row_end, out_row_end);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= 5000)
        begin
            $display("%0t: watchdog expired", $time);
            $display("RESULT: ERROR");
            $finish;
        end
    end
endmodule
`default_nettype wire

### files.f
hw/rtl/mgds_pkg.sv
hw/rtl/mgds_ctrl.sv
hw/rtl/mgds_datapath.sv
hw/rtl/masked_gamma_downsample_2x2.sv
verif/masked_gamma_downsample_2x2_tb.sv
